/* rtl/animation_frame_stepper_top_defines.svh */
// Assertion macros used by the animation frame stepper top level.
`ifndef ANIMATION_FRAME_STEPPER_TOP_DEFINES_SVH
`define ANIMATION_FRAME_STEPPER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, clocked on clk and disabled while rst_n is low.
`define AFS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("Assertion failed: same-cycle implication.");

// Next-cycle implication, clocked on clk and disabled while rst_n is low.
`define AFS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("Assertion failed: next-cycle implication.");

`else

`define AFS_ASSERT_IMP(lbl, ante, cons)
`define AFS_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

/* rtl/afs_pkg.sv */
// Types, constants and helper functions of the animation frame stepper.
package afs_pkg;

    localparam int FRAME_BITS = 16;
    localparam int SLOT_COUNT = 2;
    localparam int COUNT_BITS = 16;
    localparam int STEP_BITS = 16;
    localparam int VALUE_BITS = 16;
    localparam int MODE_BITS = 4;
    localparam int FLAG_BITS = 5;
    localparam int OUT_FRAME_BITS = 16;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS = 16;
    localparam int WIDE_BITS = (FRAME_BITS > COUNT_BITS) ? FRAME_BITS : COUNT_BITS;
    localparam int CALC_BITS = WIDE_BITS + 3;

    localparam int FLAG_REVERSE = 0;
    localparam int FLAG_PINGPONG = 1;
    localparam int FLAG_NOLOOP = 2;
    localparam int FLAG_PAUSED = 3;
    localparam int FLAG_ENDED = 4;

    typedef logic signed [CALC_BITS-1:0] calc_t;

    typedef enum logic [1:0] {
        KIND_TICK      = 2'd0,
        KIND_START     = 2'd1,
        KIND_SET_FRAME = 2'd2,
        KIND_SET_STEP  = 2'd3
    } kind_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_FRAME_COUNT_A = 2'd0,
        CFG_FRAME_COUNT_B = 2'd1,
        CFG_IN_USE_A      = 2'd2,
        CFG_IN_USE_B      = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [FRAME_BITS-1:0] frame;
        logic [STEP_BITS-1:0]  step;
        logic [FLAG_BITS-1:0]  flags;
    } slot_state_t;

    typedef struct packed {
        kind_t                 kind;
        logic                  slot;
        logic [VALUE_BITS-1:0] value;
        logic [MODE_BITS-1:0]  start_mode;
    } req_t;

    // Clamps a signed intermediate frame into the legal frame range.
    function automatic logic [FRAME_BITS-1:0] sat_frame(input calc_t v);
        calc_t top;
        top = calc_t'({FRAME_BITS{1'b1}});
        if (v < calc_t'(0)) begin
            return '0;
        end
        else if (v > top) begin
            return {FRAME_BITS{1'b1}};
        end
        else begin
            return v[FRAME_BITS-1:0];
        end
    endfunction

endpackage

/* rtl/afs_req_if.sv */
// Request channel carrying one input item of the frame stepper.
interface afs_req_if;
    import afs_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [1:0]            kind;
    logic                  slot;
    logic [VALUE_BITS-1:0] value;
    logic [MODE_BITS-1:0]  start_mode;

    modport source (output valid, output kind, output slot, output value,
                    output start_mode, input ready);
    modport sink (input valid, input kind, input slot, input value,
                  input start_mode, output ready);
endinterface

/* rtl/afs_res_if.sv */
// Result channel carrying the slot status after each request.
interface afs_res_if;
    import afs_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [OUT_FRAME_BITS-1:0] frame_a;
    logic [OUT_FRAME_BITS-1:0] frame_b;
    logic                      reverse_a;
    logic                      reverse_b;
    logic                      ended_a;
    logic                      ended_b;

    modport source (output valid, output frame_a, output frame_b, output reverse_a,
                    output reverse_b, output ended_a, output ended_b, input ready);
    modport sink (input valid, input frame_a, input frame_b, input reverse_a,
                  input reverse_b, input ended_a, input ended_b, output ready);
endinterface

/* rtl/afs_cfg_if.sv */
// Configuration write channel of the frame stepper.
interface afs_cfg_if;
    import afs_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [CFG_INDEX_BITS-1:0] index;
    logic [CFG_DATA_BITS-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

/* rtl/animation_frame_stepper_top.sv */
// Top level of the two-slot animation frame stepper.
//
//  Channel | Direction | Handshake    | Payload
//  req     | in        | valid/ready  | kind, slot, value, start_mode
//  res     | out       | valid/ready  | frame_a/b, reverse_a/b, ended_a/b
//  cfg     | in        | valid/ready  | index, data
//
// A request is held in the input register, then the slot update logic writes the result
// register, from which its result is offered; a stalled result can delay that write.
// A new request is accepted in every cycle while results are taken.
// Reset clears the frames, flags and configuration and sets both steps to one.
// A stalled result holds the input register, which then stops accepting requests.
module animation_frame_stepper_top (
    input logic      clk,
    input logic      rst_n,
    afs_req_if.sink  req,
    afs_res_if.source res,
    afs_cfg_if.sink  cfg
);
    import afs_pkg::*;

`include "animation_frame_stepper_top_defines.svh"

    logic                  s1_valid_reg;
    logic                  s1_valid_next;
    req_t                  s1_req_reg;
    logic                  s1_fire;
    logic                  req_fire;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    slot_state_t           out_state_reg [SLOT_COUNT];

    slot_state_t           state_reg [SLOT_COUNT];
    slot_state_t           state_next [SLOT_COUNT];
    slot_state_t           adv_state [SLOT_COUNT];

    logic [COUNT_BITS-1:0] count_reg [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] in_use_reg;

    calc_t                 n_sel;
    calc_t                 value_c;

    logic                  paused_tick;
    logic                  ended_b_keep;

    assign s1_fire = s1_valid_reg && (!out_valid_reg || res.ready);
    assign req.ready = !s1_valid_reg || s1_fire;
    assign req_fire = req.valid && req.ready;
    assign s1_valid_next = req_fire || (s1_valid_reg && !s1_fire);
    assign out_valid_next = s1_fire || (out_valid_reg && !res.ready);
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            s1_req_reg.kind <= kind_t'(req.kind);
            s1_req_reg.slot <= req.slot;
            s1_req_reg.value <= req.value;
            s1_req_reg.start_mode <= req.start_mode;
        end
        if (s1_fire)
        begin
            out_state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg[0] <= '0;
            count_reg[1] <= '0;
            in_use_reg <= '0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg_index_t'(cfg.index))
                CFG_FRAME_COUNT_A: count_reg[0] <= COUNT_BITS'(cfg.data);
                CFG_FRAME_COUNT_B: count_reg[1] <= COUNT_BITS'(cfg.data);
                CFG_IN_USE_A:      in_use_reg[0] <= cfg.data[0];
                CFG_IN_USE_B:      in_use_reg[1] <= cfg.data[0];
                default:           ;
            endcase
        end
    end

    for (genvar i = 0; i < SLOT_COUNT; i++)
    begin : g_slot
        afs_advance u_advance (
            .enable (in_use_reg[i]),
            .count  (count_reg[i]),
            .cur    (state_reg[i]),
            .nxt    (adv_state[i])
        );

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                state_reg[i].frame <= '0;
                state_reg[i].step <= STEP_BITS'(1);
                state_reg[i].flags <= '0;
            end
            else
            begin
                state_reg[i] <= state_next[i];
            end
        end
    end

    always_comb
    begin
        n_sel = calc_t'(count_reg[s1_req_reg.slot]);
        value_c = calc_t'(s1_req_reg.value);
        state_next = state_reg;
        if (s1_fire)
        begin
            case (s1_req_reg.kind)
                KIND_TICK:
                begin
                    state_next = adv_state;
                end
                KIND_START:
                begin
                    state_next[s1_req_reg.slot].step = STEP_BITS'(1);
                    state_next[s1_req_reg.slot].flags = FLAG_BITS'(s1_req_reg.start_mode);
                    if (s1_req_reg.start_mode[FLAG_REVERSE])
                    begin
                        state_next[s1_req_reg.slot].frame = sat_frame(n_sel - calc_t'(1));
                    end
                    else
                    begin
                        state_next[s1_req_reg.slot].frame = '0;
                    end
                end
                KIND_SET_FRAME:
                begin
                    if (n_sel == calc_t'(0))
                    begin
                        state_next[s1_req_reg.slot].frame = '0;
                    end
                    else if (value_c < n_sel - calc_t'(1))
                    begin
                        state_next[s1_req_reg.slot].frame = sat_frame(value_c);
                    end
                    else
                    begin
                        state_next[s1_req_reg.slot].frame = sat_frame(n_sel - calc_t'(1));
                    end
                end
                KIND_SET_STEP:
                begin
                    state_next[s1_req_reg.slot].step = STEP_BITS'(s1_req_reg.value);
                end
                default:
                begin
                    state_next = state_reg;
                end
            endcase
        end
    end

    assign res.valid = out_valid_reg;
    assign res.frame_a = OUT_FRAME_BITS'(out_state_reg[0].frame);
    assign res.frame_b = OUT_FRAME_BITS'(out_state_reg[1].frame);
    assign res.reverse_a = out_state_reg[0].flags[FLAG_REVERSE];
    assign res.reverse_b = out_state_reg[1].flags[FLAG_REVERSE];
    assign res.ended_a = out_state_reg[0].flags[FLAG_ENDED];
    assign res.ended_b = out_state_reg[1].flags[FLAG_ENDED];

    assign paused_tick = s1_fire && s1_req_reg.kind == KIND_TICK
                         && state_reg[0].flags[FLAG_PAUSED];
    assign ended_b_keep = state_reg[1].flags[FLAG_ENDED]
                          && !(s1_fire && s1_req_reg.kind == KIND_START
                               && s1_req_reg.slot == 1'b1);

    // A paused slot keeps its frame across a tick.
    `AFS_ASSERT_NEXT(a_paused_holds, paused_tick, $stable(state_reg[0].frame))

    // Only a start request on the slot clears its ended flag.
    `AFS_ASSERT_NEXT(a_ended_sticky, ended_b_keep, state_reg[1].flags[FLAG_ENDED])

    // A new result appears only after the input register handed over a request.
    `AFS_ASSERT_IMP(a_result_source, $rose(out_valid_reg), $past(s1_fire))

    // State changes only when a request moves out of the input register.
    `AFS_ASSERT_NEXT(a_state_quiet, !s1_fire, $stable(state_reg[0]) && $stable(state_reg[1]))

endmodule

/* rtl/afs_advance.sv */
// Tick update of one slot: forward, reverse and ping-pong stepping, with a no-loop end.
module afs_advance (
    input  logic                           enable,
    input  logic [afs_pkg::COUNT_BITS-1:0] count,
    input  afs_pkg::slot_state_t           cur,
    output afs_pkg::slot_state_t           nxt
);
    import afs_pkg::*;

    calc_t                f;
    calc_t                st;
    calc_t                n;
    calc_t                r;
    logic [FLAG_BITS-1:0] fl;

    always_comb
    begin
        f = calc_t'(cur.frame);
        st = calc_t'(cur.step);
        n = calc_t'(count);
        fl = cur.flags;
        r = f;
        nxt = cur;
        if (enable && !fl[FLAG_PAUSED] && !fl[FLAG_ENDED])
        begin
            if (fl[FLAG_PINGPONG])
            begin
                if (fl[FLAG_REVERSE])
                begin
                    if (f <= st)
                    begin
                        r = st - f;
                        fl[FLAG_REVERSE] = 1'b0;
                    end
                    else
                    begin
                        r = f - st;
                    end
                end
                else
                begin
                    r = f + st;
                    if (r >= n - calc_t'(1))
                    begin
                        r = n + n - r - calc_t'(2);
                        fl[FLAG_REVERSE] = 1'b1;
                    end
                end
            end
            else if (fl[FLAG_REVERSE])
            begin
                if (f > st)
                begin
                    r = f - st;
                end
                else if (fl[FLAG_NOLOOP])
                begin
                    r = calc_t'(0);
                    fl[FLAG_ENDED] = 1'b1;
                end
                else if (f == st)
                begin
                    r = calc_t'(0);
                end
                else
                begin
                    r = n - (st - f);
                end
            end
            else
            begin
                r = f + st;
                if (r >= n - calc_t'(1))
                begin
                    if (fl[FLAG_NOLOOP])
                    begin
                        r = n - calc_t'(1);
                        fl[FLAG_ENDED] = 1'b1;
                    end
                    else if (r >= n)
                    begin
                        r = r - n;
                    end
                end
            end
            nxt.frame = sat_frame(r);
            nxt.flags = fl;
        end
    end
endmodule

/* test/tb.sv */
// Self-checking testbench for the animation frame stepper: directed and random requests.
module tb;
    import afs_pkg::*;

    localparam int HOLD_CYCLES = 64;
    localparam int PHASE_REQUESTS = 190;
    localparam int PHASES = 8;
    localparam longint TIMEOUT = 4000000;
    localparam logic [MODE_BITS-1:0] M_REV = MODE_BITS'(1 << FLAG_REVERSE);
    localparam logic [MODE_BITS-1:0] M_PING = MODE_BITS'(1 << FLAG_PINGPONG);
    localparam logic [MODE_BITS-1:0] M_NOLOOP = MODE_BITS'(1 << FLAG_NOLOOP);
    localparam logic [MODE_BITS-1:0] M_PAUSE = MODE_BITS'(1 << FLAG_PAUSED);

    typedef struct packed {
        logic [OUT_FRAME_BITS-1:0] frame_a;
        logic [OUT_FRAME_BITS-1:0] frame_b;
        logic                      reverse_a;
        logic                      reverse_b;
        logic                      ended_a;
        logic                      ended_b;
    } status_t;

    class frame_tracker;
        logic [FRAME_BITS-1:0] frame [SLOT_COUNT];
        logic [STEP_BITS-1:0]  step [SLOT_COUNT];
        logic [FLAG_BITS-1:0]  flags [SLOT_COUNT];
        logic [COUNT_BITS-1:0] count [SLOT_COUNT];
        logic                  in_use [SLOT_COUNT];
        status_t               pending_status [$];
        int                    mismatches;

        function new();
            for (int s = 0; s < SLOT_COUNT; s++)
            begin
                frame[s] = '0;
                step[s] = STEP_BITS'(1);
                flags[s] = '0;
                count[s] = '0;
                in_use[s] = 1'b0;
            end
            mismatches = 0;
        endfunction

        function void write_reg(cfg_index_t idx, logic [CFG_DATA_BITS-1:0] data);
            case (idx)
                CFG_FRAME_COUNT_A: count[0] = data;
                CFG_FRAME_COUNT_B: count[1] = data;
                CFG_IN_USE_A:      in_use[0] = data[0];
                CFG_IN_USE_B:      in_use[1] = data[0];
                default:           ;
            endcase
        endfunction

        function logic [FRAME_BITS-1:0] clip(longint v);
            if (v < 0)
                return '0;
            if (v > (longint'(1) << FRAME_BITS) - 1)
                return '1;
            return v[FRAME_BITS-1:0];
        endfunction

        function void advance(int s);
            logic [FLAG_BITS-1:0] fl;
            longint f;
            longint st;
            longint n;
            longint r;
            fl = flags[s];
            f = longint'(frame[s]);
            st = longint'(step[s]);
            n = longint'(count[s]);
            if (fl[FLAG_PAUSED] || fl[FLAG_ENDED])
                return;
            if (fl[FLAG_PINGPONG])
            begin
                if (fl[FLAG_REVERSE])
                begin
                    if (f <= st)
                    begin
                        r = st - f;
                        fl[FLAG_REVERSE] = ~fl[FLAG_REVERSE];
                    end
                    else
                        r = f - st;
                end
                else
                begin
                    r = f + st;
                    if (r >= n - 1)
                    begin
                        r = 2 * n - r - 2;
                        fl[FLAG_REVERSE] = ~fl[FLAG_REVERSE];
                    end
                end
            end
            else if (fl[FLAG_REVERSE])
            begin
                if (f > st)
                    r = f - st;
                else if (fl[FLAG_NOLOOP])
                begin
                    r = 0;
                    fl[FLAG_ENDED] = 1'b1;
                end
                else if (f == st)
                    r = 0;
                else
                    r = n - (st - f);
            end
            else
            begin
                r = f + st;
                if (r >= n - 1)
                begin
                    if (fl[FLAG_NOLOOP])
                    begin
                        r = n - 1;
                        fl[FLAG_ENDED] = 1'b1;
                    end
                    else if (r >= n)
                        r = r - n;
                end
            end
            frame[s] = clip(r);
            flags[s] = fl;
        endfunction

        function void note_request(req_t rq);
            int s;
            status_t st;
            s = int'(rq.slot);
            case (rq.kind)
                KIND_TICK:
                begin
                    for (int i = 0; i < SLOT_COUNT; i++)
                        if (in_use[i])
                            advance(i);
                end
                KIND_START:
                begin
                    step[s] = STEP_BITS'(1);
                    flags[s] = {1'b0, rq.start_mode};
                    frame[s] = rq.start_mode[FLAG_REVERSE] ? clip(longint'(count[s]) - 1) : '0;
                end
                KIND_SET_FRAME:
                begin
                    if (count[s] == 0)
                        frame[s] = '0;
                    else if (rq.value < count[s] - 1)
                        frame[s] = clip(longint'(rq.value));
                    else
                        frame[s] = clip(longint'(count[s]) - 1);
                end
                default:
                    step[s] = rq.value;
            endcase
            st.frame_a = frame[0];
            st.frame_b = frame[1];
            st.reverse_a = flags[0][FLAG_REVERSE];
            st.reverse_b = flags[1][FLAG_REVERSE];
            st.ended_a = flags[0][FLAG_ENDED];
            st.ended_b = flags[1][FLAG_ENDED];
            pending_status.insert(pending_status.size(), st);
        endfunction

        function void compare(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0d, actual %0d", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_status(status_t got);
            status_t want;
            if (pending_status.size() == 0)
            begin
                $error("result with no request outstanding: frame_a %0d frame_b %0d",
                       got.frame_a, got.frame_b);
                mismatches++;
                return;
            end
            want = pending_status.pop_front();
            compare("frame_a", want.frame_a, got.frame_a);
            compare("frame_b", want.frame_b, got.frame_b);
            compare("reverse_a", 16'(want.reverse_a), 16'(got.reverse_a));
            compare("reverse_b", 16'(want.reverse_b), 16'(got.reverse_b));
            compare("ended_a", 16'(want.ended_a), 16'(got.ended_a));
            compare("ended_b", 16'(want.ended_b), 16'(got.ended_b));
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    int   send_idle_pct = 0;
    int   stall_pct = 0;
    bit   hold_request = 1'b0;

    frame_tracker tracker = new();

    afs_req_if req();
    afs_res_if res();
    afs_cfg_if cfg();

    animation_frame_stepper_top DUT (
        .clk(clk),
        .rst_n(rst_n),
        .req(req),
        .res(res),
        .cfg(cfg)
    );

    always #10 clk = ~clk;

    function automatic req_t req_of(kind_t k, logic s, logic [VALUE_BITS-1:0] v,
                                    logic [MODE_BITS-1:0] m);
        req_t rq;
        rq.kind = k;
        rq.slot = s;
        rq.value = v;
        rq.start_mode = m;
        return rq;
    endfunction

    function automatic req_t random_request();
        req_t rq;
        int pick;
        int lim;
        rq.slot = 1'($urandom_range(1));
        rq.value = VALUE_BITS'($urandom);
        rq.start_mode = MODE_BITS'($urandom);
        lim = int'(tracker.count[rq.slot]) + 2;
        pick = $urandom_range(99);
        if (pick < 55)
            rq.kind = KIND_TICK;
        else if (pick < 70)
        begin
            rq.kind = KIND_START;
            if ($urandom_range(5) != 0)
                rq.start_mode[FLAG_PAUSED] = 1'b0;
        end
        else if (pick < 85)
        begin
            rq.kind = KIND_SET_STEP;
            if ($urandom_range(3) != 0)
                rq.value = VALUE_BITS'($urandom_range(lim > 8 ? lim / 4 : lim));
        end
        else
        begin
            rq.kind = KIND_SET_FRAME;
            if ($urandom_range(3) != 0)
                rq.value = VALUE_BITS'($urandom_range(lim));
        end
        return rq;
    endfunction

    task automatic send_request(input req_t rq);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req.valid <= 1'b0;
            @(negedge clk);
        end
        req.valid <= 1'b1;
        req.kind <= rq.kind;
        req.slot <= rq.slot;
        req.value <= rq.value;
        req.start_mode <= rq.start_mode;
        do
        begin
            @(posedge clk);
        end
        while (!req.ready);
        tracker.note_request(rq);
        @(negedge clk);
    endtask

    task automatic cfg_write(input cfg_index_t idx, input logic [CFG_DATA_BITS-1:0] data);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= data;
        do
        begin
            @(posedge clk);
        end
        while (!cfg.ready);
        tracker.write_reg(idx, data);
        @(negedge clk);
    endtask

    task automatic write_settings(input logic [15:0] cnt_a, input logic [15:0] cnt_b,
                                  input logic use_a, input logic use_b);
        cfg_write(CFG_FRAME_COUNT_A, cnt_a);
        cfg_write(CFG_FRAME_COUNT_B, cnt_b);
        cfg_write(CFG_IN_USE_A, CFG_DATA_BITS'(use_a));
        cfg_write(CFG_IN_USE_B, CFG_DATA_BITS'(use_b));
        cfg.valid <= 1'b0;
    endtask

    task automatic wait_idle();
        req.valid <= 1'b0;
        while (tracker.pending_status.size() != 0)
            @(posedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_pace(input int mode);
        case (mode)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 81; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 81; end
            default: begin send_idle_pct = 30; stall_pct = 30; end
        endcase
    endtask

    initial
    begin
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        res.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request && !hold_done)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                res.ready <= 1'b0;
                hold_left--;
            end
            else
                res.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && res.valid && res.ready)
            tracker.check_status({res.frame_a, res.frame_b, res.reverse_a, res.reverse_b,
                                  res.ended_a, res.ended_b});
    end

    initial
    begin
        #TIMEOUT;
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        logic [15:0] cnt_a [PHASES];
        logic [15:0] cnt_b [PHASES];
        logic        use_a [PHASES];
        logic        use_b [PHASES];
        req_t        tick;
        cnt_a = '{16'd7, 16'hFFFF, 16'd1, 16'd0, 16'd2, 16'd0, 16'hFFFF, 16'd0};
        cnt_b = '{16'd12, 16'd0, 16'hFFFF, 16'd3, 16'd1, 16'd0, 16'hFFFF, 16'd0};
        use_a = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0};
        use_b = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0};
        cnt_a[5] = 16'($urandom_range(40));
        cnt_b[5] = 16'($urandom_range(40));
        cnt_a[7] = 16'($urandom);
        cnt_b[7] = 16'($urandom_range(20));
        tick = req_of(KIND_TICK, 1'b0, '0, '0);

        rst_n = 1'b0;
        req.valid = 1'b0;
        req.kind = KIND_TICK;
        req.slot = 1'b0;
        req.value = '0;
        req.start_mode = '0;
        cfg.valid = 1'b0;
        cfg.index = CFG_FRAME_COUNT_A;
        cfg.data = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        write_settings(16'd5, 16'd0, 1'b1, 1'b1);
        set_pace(0);
        send_request(req_of(KIND_START, 1'b0, '0, '0));
        send_request(req_of(KIND_SET_STEP, 1'b0, 16'd3, '0));
        repeat (2) send_request(tick);
        send_request(req_of(KIND_SET_STEP, 1'b1, 16'hFFFF, 4'hF));
        send_request(tick);
        send_request(req_of(KIND_SET_FRAME, 1'b0, 16'hFFFF, '0));
        send_request(req_of(KIND_SET_FRAME, 1'b1, 16'h1234, '0));
        send_request(req_of(KIND_SET_STEP, 1'b0, 16'd0, '0));
        send_request(tick);
        send_request(req_of(KIND_START, 1'b0, 16'hFFFF, M_REV | M_NOLOOP));
        send_request(req_of(KIND_SET_STEP, 1'b0, 16'd2, '0));
        repeat (3) send_request(tick);
        send_request(req_of(KIND_START, 1'b0, '0, M_PING));
        send_request(req_of(KIND_SET_STEP, 1'b0, 16'd3, '0));
        repeat (3) send_request(tick);
        send_request(req_of(KIND_START, 1'b1, '0, M_REV | M_PING | M_NOLOOP | M_PAUSE));
        send_request(tick);
        send_request(req_of(KIND_START, 1'b1, '0, M_REV));
        send_request(tick);

        for (int p = 0; p < PHASES; p++)
        begin
            wait_idle();
            write_settings(cnt_a[p], cnt_b[p], use_a[p], use_b[p]);
            set_pace(p % 4);
            for (int i = 0; i < PHASE_REQUESTS; i++)
            begin
                if (p == 0 && i == 30)
                    hold_request = 1'b1;
                send_request(random_request());
            end
        end

        wait_idle();
        repeat (8) @(posedge clk);
        if (tracker.mismatches == 0 && tracker.pending_status.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
